// ----- rtl/bmf_pkg.sv -----
// ----------------------------------------------------------------------------
// bmf_pkg
// Shared types and codes of the binary morphology filter: register map,
// mode and item codes, result record and the 3x3 window operator.
// ----------------------------------------------------------------------------
package bmf_pkg;

  localparam int CfgAddrW = 4;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic MODE_DILATE = 1'b0;
  localparam logic MODE_ERODE  = 1'b1;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  localparam logic [10:0] SIZE_RESET = 11'd1024;

  typedef struct packed {
    logic frame_end;
    logic row_end;
    logic pixel;
  } bmf_result_t;

  // window bit index is col*3 + row, row 0 is the oldest line
  function automatic logic bmf_filter(input logic mode, input logic [8:0] win,
                                      input logic top, input logic bot,
                                      input logic left, input logic right);
    logic [2:0] cm;
    logic [2:0] rm;
    logic       res;
    cm = {right, 1'b1, left};
    rm = {bot, 1'b1, top};
    if (mode == MODE_ERODE) begin
      res = win[4] & (~top | win[3]) & (~bot | win[5]) &
            (~left | win[1]) & (~right | win[7]);
    end else begin
      res = 1'b0;
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          res = res | (win[c*3+r] & cm[c] & rm[r]);
        end
      end
    end
    return res;
  endfunction

endpackage

// ----- rtl/bmf_ram.sv -----
// ----------------------------------------------------------------------------
// bmf_ram
// Single write port, single read port memory with registered read data and
// write-to-read forwarding on an address match.
// ----------------------------------------------------------------------------
module bmf_ram #(
  parameter int DATA_W = 2,
  parameter int DEPTH  = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/binary_morphology_filter.sv -----
// ----------------------------------------------------------------------------
// binary_morphology_filter
// One pass of 3x3 binary dilation or 4-neighbour erosion over a raster frame
// of one-bit pixels.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one item per transfer; in_tuser is the item kind (pixel or drain),
//            in_tdata[0] the pixel in raster order.
//   out_*  : one filtered pixel per transfer; out_tdata[0] the pixel,
//            out_tuser marks the last pixel of a row, out_tlast of the frame.
//   cfg_*  : APB registers mode (0x0), frame_width (0x4), frame_height (0x8).
// Throughput: one item per cycle when not stalled; the line stores are read
//   one column ahead so each item needs one read and one write of each memory
//   port per cycle. A pixel's result is produced by the item frame_width+1
//   advancing items later and registered in the output stage; after the
//   last pixel of a frame, frame_width+1 drain items flush the tail.
// Reset: registers return to dilate, 1024 x 1024; stream state is cleared,
//   no clearing pass is needed.
// Stall: a two-entry output stage holds results; in_tready drops only when
//   both entries are full.
// ----------------------------------------------------------------------------
module binary_morphology_filter #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [bmf_pkg::CfgAddrW-1:0]  cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [0] pixel
  input  logic                          in_tuser,   // [0] kind
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [7:0]                    out_tdata,  // [0] pixel_out
  output logic                          out_tlast,  // frame_end
  output logic                          out_tuser   // [0] row_end
);

  import bmf_pkg::*;

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int CMPW = CW + 1;
  localparam int HW   = $clog2(MAX_HEIGHT);
  localparam int HWW  = $clog2(MAX_HEIGHT + 1);
  localparam int HCW  = HW + 1;
  localparam int FW   = $clog2(MAX_WIDTH + 2);

  // configuration
  logic           mode_r;
  logic [10:0]    fw_r;
  logic [10:0]    fh_r;
  logic [WW-1:0]  w_eff_r;
  logic [HWW-1:0] h_eff_r;
  logic [WW-1:0]  w_eff_nxt;
  logic [HWW-1:0] h_eff_nxt;
  logic           cfg_wr;
  logic           sz_wr;
  logic [1:0]     cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign sz_wr      = cfg_wr && ((cfg_idx == REG_WIDTH) || (cfg_idx == REG_HEIGHT));

  always_comb begin
    if (cfg_pwdata[10:0] == 11'd0) begin
      w_eff_nxt = WW'(1);
      h_eff_nxt = HWW'(1);
    end else begin
      w_eff_nxt = ({21'd0, cfg_pwdata[10:0]} > MAX_WIDTH) ? WW'(MAX_WIDTH)
                                                          : WW'(cfg_pwdata[10:0]);
      h_eff_nxt = ({21'd0, cfg_pwdata[10:0]} > MAX_HEIGHT) ? HWW'(MAX_HEIGHT)
                                                           : HWW'(cfg_pwdata[10:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_DILATE;
      fw_r    <= SIZE_RESET;
      fh_r    <= SIZE_RESET;
      w_eff_r <= ({21'd0, SIZE_RESET} > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(SIZE_RESET);
      h_eff_r <= ({21'd0, SIZE_RESET} > MAX_HEIGHT) ? HWW'(MAX_HEIGHT) : HWW'(SIZE_RESET);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MODE: begin
          mode_r <= cfg_pwdata[0];
        end
        REG_WIDTH: begin
          fw_r    <= cfg_pwdata[10:0];
          w_eff_r <= w_eff_nxt;
        end
        REG_HEIGHT: begin
          fh_r    <= cfg_pwdata[10:0];
          h_eff_r <= h_eff_nxt;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_MODE:   cfg_prdata = {31'd0, mode_r};
      REG_WIDTH:  cfg_prdata = {21'd0, fw_r};
      REG_HEIGHT: cfg_prdata = {21'd0, fh_r};
      default:    cfg_prdata = 32'd0;
    endcase
  end

  // stream state
  logic [CW-1:0] stream_col_r, stream_col_nxt;
  logic [WW-1:0] delay_pos_r, delay_pos_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [FW-1:0] pending_r, pending_nxt;
  logic [8:0]    win_r, win_nxt;
  logic [CW-1:0] in_col_r, in_col_nxt;
  logic [HW-1:0] in_row_r, in_row_nxt;
  logic [CW-1:0] out_col_r, out_col_nxt;
  logic [HW-1:0] out_row_r, out_row_nxt;

  logic          acc;
  logic          is_pix;
  logic          adv;
  logic          pix;
  logic [1:0]    line_q;
  logic          vld_q;
  logic          was;
  logic          emit;
  logic [8:0]    win_new;
  logic          top, bot, left, right;
  bmf_result_t   res;

  bmf_ram #(
    .DATA_W (2),
    .DEPTH  (MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (adv),
    .waddr (stream_col_r),
    .wdata ({line_q[0], pix}),
    .raddr (stream_col_nxt),
    .rdata (line_q)
  );

  bmf_ram #(
    .DATA_W (1),
    .DEPTH  (MAX_WIDTH + 1)
  ) u_valid (
    .clk   (clk),
    .we    (adv),
    .waddr (delay_pos_r),
    .wdata (is_pix),
    .raddr (delay_pos_nxt),
    .rdata (vld_q)
  );

  assign acc     = in_tvalid && in_tready;
  assign is_pix  = (in_tuser == KIND_PIXEL);
  assign adv     = acc && (is_pix || ((in_col_r == '0) && (in_row_r == '0) &&
                                      (pending_r != '0)));
  assign pix     = is_pix & in_tdata[0];
  assign was     = vld_q && (fill_r == FW'(w_eff_r) + FW'(1));
  assign emit    = adv && was;
  // line entry holds {upper, middle}
  assign win_new = {pix, line_q[0], line_q[1], win_r[8:3]};

  assign top   = (out_row_r != '0);
  assign bot   = (HCW'(out_row_r) + HCW'(1) < HCW'(h_eff_r));
  assign left  = (out_col_r != '0);
  assign right = (CMPW'(out_col_r) + CMPW'(1) < CMPW'(w_eff_r));

  always_comb begin
    res.pixel     = bmf_filter(mode_r, win_new, top, bot, left, right);
    res.row_end   = !right;
    res.frame_end = !right && !bot;
  end

  always_comb begin
    stream_col_nxt = stream_col_r;
    delay_pos_nxt  = delay_pos_r;
    fill_nxt       = fill_r;
    pending_nxt    = pending_r;
    win_nxt        = win_r;
    in_col_nxt     = in_col_r;
    in_row_nxt     = in_row_r;
    out_col_nxt    = out_col_r;
    out_row_nxt    = out_row_r;
    if (sz_wr) begin
      stream_col_nxt = '0;
      delay_pos_nxt  = '0;
      fill_nxt       = '0;
      pending_nxt    = '0;
      win_nxt        = '0;
      in_col_nxt     = '0;
      in_row_nxt     = '0;
      out_col_nxt    = '0;
      out_row_nxt    = '0;
    end else begin
      if (adv) begin
        win_nxt        = win_new;
        stream_col_nxt = (CMPW'(stream_col_r) + CMPW'(1) == CMPW'(w_eff_r)) ? '0
                         : stream_col_r + CW'(1);
        delay_pos_nxt  = (delay_pos_r == w_eff_r) ? '0 : delay_pos_r + WW'(1);
        if (fill_r != FW'(w_eff_r) + FW'(1)) begin
          fill_nxt = fill_r + FW'(1);
        end
        pending_nxt = pending_r + FW'(is_pix) - FW'(was);
      end
      if (acc && is_pix) begin
        if (CMPW'(in_col_r) + CMPW'(1) >= CMPW'(w_eff_r)) begin
          in_col_nxt = '0;
          in_row_nxt = (HCW'(in_row_r) + HCW'(1) >= HCW'(h_eff_r)) ? '0
                       : in_row_r + HW'(1);
        end else begin
          in_col_nxt = in_col_r + CW'(1);
        end
      end
      if (emit) begin
        if (res.frame_end) begin
          out_col_nxt = '0;
          out_row_nxt = '0;
        end else if (res.row_end) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + HW'(1);
        end else begin
          out_col_nxt = out_col_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stream_col_r <= '0;
      delay_pos_r  <= '0;
      fill_r       <= '0;
      pending_r    <= '0;
      win_r        <= '0;
      in_col_r     <= '0;
      in_row_r     <= '0;
      out_col_r    <= '0;
      out_row_r    <= '0;
    end else begin
      stream_col_r <= stream_col_nxt;
      delay_pos_r  <= delay_pos_nxt;
      fill_r       <= fill_nxt;
      pending_r    <= pending_nxt;
      win_r        <= win_nxt;
      in_col_r     <= in_col_nxt;
      in_row_r     <= in_row_nxt;
      out_col_r    <= out_col_nxt;
      out_row_r    <= out_row_nxt;
    end
  end

  // output register with skid entry
  logic        out_valid_r;
  logic        skid_valid_r;
  bmf_result_t out_data_r;
  bmf_result_t skid_data_r;
  logic        pop;

  assign in_tready = !skid_valid_r;
  assign pop       = out_valid_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || pop) begin
      out_valid_r  <= skid_valid_r || emit;
      skid_valid_r <= 1'b0;
    end else if (emit) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || pop) begin
      out_data_r <= skid_valid_r ? skid_data_r : res;
    end else if (emit) begin
      skid_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_data_r.pixel};
  assign out_tuser  = out_data_r.row_end;
  assign out_tlast  = out_data_r.frame_end;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry full while output register empty");

  a_pending_le_fill: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= fill_r)
    else $error("more pending pixels than stream slots filled");

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (CMPW'(stream_col_r) < CMPW'(w_eff_r)) && (delay_pos_r <= w_eff_r))
    else $error("stream position beyond frame width");

  a_no_result_when_stalled_full: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_tready) |=> skid_valid_r && $stable(skid_data_r))
    else $error("skid entry lost under stall");
`endif

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the binary morphology filter. A clocked driver feeds
// pixel and drain items from a queue, and a behavioral line-store predictor
// works out each filtered pixel with its row and frame markers. A clocked
// monitor compares every output transfer against the oldest prediction. Both
// stream sides stall at random, and frame size and mode change between phases.
// ----------------------------------------------------------------------------
module testbench;
  import bmf_pkg::*;

  localparam int MAX_W         = 1024;
  localparam int MAX_H         = 1024;
  localparam int RANDOM_ITEMS  = 480;
  localparam int TAIL_DRAINS   = 24;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 12;

  localparam logic [1:0] REG_SPARE = 2'd3;

  localparam logic [8:0] DIR_A = 9'b110_000_001;
  localparam logic [8:0] DIR_B = 9'b111_111_110;

  typedef struct packed {
    logic kind;
    logic pixel;
  } mask_item_t;

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                cfg_psel    = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite  = 1'b0;
  logic [CfgAddrW-1:0] cfg_paddr   = '0;
  logic [31:0]         cfg_pwdata  = '0;
  logic [31:0]         cfg_prdata;
  logic                cfg_pready;
  logic                in_tvalid   = 1'b0;
  logic                in_tready;
  logic [7:0]          in_tdata    = '0;   // [0] pixel
  logic                in_tuser    = 1'b0; // [0] kind
  logic                out_tvalid;
  logic                out_tready  = 1'b0;
  logic [7:0]          out_tdata;          // [0] pixel_out
  logic                out_tlast;
  logic                out_tuser;          // [0] row_end

  binary_morphology_filter #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  bit          upper_px[MAX_W];
  bit          middle_px[MAX_W];
  bit          slot_live[MAX_W+1];
  logic [8:0]  win3;
  int unsigned in_col, in_row, out_col, out_row;
  int unsigned line_col, slot_pos, live_count;
  logic        mode_q;
  logic [10:0] width_q, height_q;

  mask_item_t  mask_items[$];
  bmf_result_t filtered_q[$];
  int          mismatches   = 0;
  int          results_seen = 0;
  int          frames_sent  = 0;
  int          cycles       = 0;
  int          in_gap       = 0;
  int          out_hold     = 0;
  bit          steady       = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned eff_dim(logic [10:0] v, int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return {21'd0, v};
  endfunction

  function automatic void clear_stream();
    foreach (upper_px[i]) begin
      upper_px[i]  = 1'b0;
      middle_px[i] = 1'b0;
    end
    foreach (slot_live[i]) slot_live[i] = 1'b0;
    win3       = '0;
    in_col     = 0;
    in_row     = 0;
    out_col    = 0;
    out_row    = 0;
    line_col   = 0;
    slot_pos   = 0;
    live_count = 0;
  endfunction

  // shifts one stream slot in, returns whether the retired slot held a pixel
  function automatic bit shift_in(bit p, bit live);
    int unsigned w, pc, lp;
    bit          u, m, retired;
    w  = eff_dim(width_q, MAX_W);
    pc = (line_col < w) ? line_col : 0;
    lp = (slot_pos <= w) ? slot_pos : 0;
    u  = upper_px[pc];
    m  = middle_px[pc];
    upper_px[pc]  = m;
    middle_px[pc] = p;
    win3     = {p, m, u, win3[8:3]};
    line_col = (pc + 1 == w) ? 0 : pc + 1;
    retired  = slot_live[lp];
    slot_live[lp] = live;
    slot_pos = (lp + 1 == w + 1) ? 0 : lp + 1;
    if (live) live_count++;
    if (retired) live_count--;
    return retired;
  endfunction

  function automatic bmf_result_t filtered_pixel();
    int unsigned w, h;
    bit          top, bot, left, right, hit;
    bmf_result_t res;
    w     = eff_dim(width_q, MAX_W);
    h     = eff_dim(height_q, MAX_H);
    top   = out_row > 0;
    bot   = out_row + 1 < h;
    left  = out_col > 0;
    right = out_col + 1 < w;
    if (mode_q == MODE_ERODE) begin
      hit = win3[4];
      if (top && !win3[3]) hit = 1'b0;
      if (bot && !win3[5]) hit = 1'b0;
      if (left && !win3[1]) hit = 1'b0;
      if (right && !win3[7]) hit = 1'b0;
    end else begin
      hit = 1'b0;
      for (int ci = 0; ci < 3; ci++) begin
        for (int ri = 0; ri < 3; ri++) begin
          if (!((ci == 0 && !left) || (ci == 2 && !right) ||
                (ri == 0 && !top) || (ri == 2 && !bot)))
            hit = hit | win3[ci*3+ri];
        end
      end
    end
    res.pixel     = hit;
    res.row_end   = (out_col + 1 >= w);
    res.frame_end = res.row_end && (out_row + 1 >= h);
    if (res.frame_end) begin
      out_row = 0;
      out_col = 0;
    end else if (res.row_end) begin
      out_row++;
      out_col = 0;
    end else begin
      out_col++;
    end
    return res;
  endfunction

  function automatic void morph_step(logic kind, logic p);
    int unsigned w, h;
    bit          retired;
    w = eff_dim(width_q, MAX_W);
    h = eff_dim(height_q, MAX_H);
    if (kind == KIND_PIXEL) begin
      retired = shift_in(p, 1'b1);
      if (in_col + 1 >= w) begin
        in_col = 0;
        in_row = (in_row + 1 >= h) ? 0 : in_row + 1;
      end else begin
        in_col++;
      end
    end else begin
      if (in_col != 0 || in_row != 0 || live_count == 0) return;
      retired = shift_in(1'b0, 1'b0);
    end
    if (retired) filtered_q.insert(filtered_q.size(), filtered_pixel());
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap    <= 0;
    end else begin
      if (in_tvalid && in_tready) morph_step(in_tuser, in_tdata[0]);
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap    <= in_gap - 1;
          in_tvalid <= 1'b0;
        end else if (mask_items.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tuser  <= mask_items[0].kind;
          in_tdata  <= {7'd0, mask_items[0].pixel};
          void'(mask_items.pop_front());
          in_gap    <= steady ? 0 : $urandom_range(0, 6);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    bmf_result_t want;
    int          hold;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_hold   <= 0;
    end else if (out_tvalid && out_tready) begin
      results_seen++;
      if (filtered_q.size() == 0) begin
        $error("transfer with no pixel expected: pixel_out %0b row_end %0b frame_end %0b",
               out_tdata[0], out_tuser, out_tlast);
        mismatches++;
      end else begin
        want = filtered_q.pop_front();
        if (out_tdata !== {7'd0, want.pixel}) begin
          $error("pixel_out expected %0h actual %0h", {7'd0, want.pixel}, out_tdata);
          mismatches++;
        end
        if (out_tuser !== want.row_end) begin
          $error("row_end expected %0b actual %0b", want.row_end, out_tuser);
          mismatches++;
        end
        if (out_tlast !== want.frame_end) begin
          $error("frame_end expected %0b actual %0b", want.frame_end, out_tlast);
          mismatches++;
        end
      end
      hold = steady ? 0 : $urandom_range(0, 6);
      out_hold   <= hold;
      out_tready <= (hold == 0);
    end else if (out_hold > 0) begin
      out_hold   <= out_hold - 1;
      out_tready <= (out_hold == 1);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic wait_idle();
    do @(negedge clk);
    while (mask_items.size() > 0 || in_tvalid || filtered_q.size() > 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] value);
    wait_idle();
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= CfgAddrW'({idx, 2'b00});
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk);
    while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_MODE: mode_q = value[0];
      REG_WIDTH: begin
        width_q = value[10:0];
        clear_stream();
      end
      REG_HEIGHT: begin
        height_q = value[10:0];
        clear_stream();
      end
      default: ;
    endcase
    @(negedge clk);
  endtask

  function automatic void add_item(logic kind, logic p);
    mask_items.insert(mask_items.size(), mask_item_t'{kind, p});
  endfunction

  task automatic push_drain();
    add_item(KIND_DRAIN, 1'($urandom_range(0, 1)));
  endtask

  task automatic queue_frames(int unsigned w, int unsigned h, int frames, int density,
                              bit noisy, bit broken, output int queued);
    int unsigned total, cut;
    queued = 0;
    total  = w * h;
    for (int f = 0; f < frames; f++) begin
      cut = (broken && f == frames - 1) ? $urandom_range(0, total - 1) : total;
      for (int unsigned i = 0; i < cut; i++) begin
        if (noisy && i > 0 && $urandom_range(0, 15) == 0) push_drain();
        add_item(KIND_PIXEL, 1'($urandom_range(1, 8) <= density));
        queued++;
      end
      if (cut == total) frames_sent++;
      if (!broken && $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          push_drain();
          queued++;
        end
      end
    end
    if (!broken) begin
      repeat (w + 1) begin
        push_drain();
        queued++;
      end
    end
  endtask

  initial begin : stimulus
    int unsigned w, h;
    int          queued;
    int          random_items;
    logic        m;
    random_items = 0;
    mode_q   = MODE_DILATE;
    width_q  = SIZE_RESET;
    height_q = SIZE_RESET;
    clear_stream();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: 3x3 frames, ignored drains, mode change over a pending tail
    cfg_write(REG_SPARE, 32'h0000_0002);
    cfg_write(REG_WIDTH, 32'hFFFF_F803);
    cfg_write(REG_HEIGHT, 32'd3);
    cfg_write(REG_MODE, 32'(MODE_DILATE));
    add_item(KIND_DRAIN, 1'b1);
    for (int i = 0; i < 9; i++) begin
      if (i == 4) add_item(KIND_DRAIN, 1'b0);
      add_item(KIND_PIXEL, DIR_A[i]);
    end
    frames_sent++;
    cfg_write(REG_MODE, 32'(MODE_ERODE));
    for (int i = 0; i < 9; i++) add_item(KIND_PIXEL, DIR_B[i]);
    frames_sent++;
    repeat (5) add_item(KIND_DRAIN, 1'b0);

    // random frames, mostly small, some broken off by a size change
    while (random_items < RANDOM_ITEMS) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      h = $urandom_range(1, 8);
      m = 1'($urandom_range(0, 1));
      cfg_write(REG_WIDTH, ($urandom() & ~32'h7FF) | w);
      cfg_write(REG_HEIGHT, ($urandom() & ~32'h7FF) | h);
      cfg_write(REG_MODE, ($urandom() & ~32'h1) | 32'(m));
      steady = ($urandom_range(0, 4) == 0);
      queue_frames(w, h, $urandom_range(1, 4), $urandom_range(0, 8),
                   1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0, queued);
      random_items += queued;
    end

    // size extremes: zero sizes act as one, an oversized width clamps to the limit
    steady = 1'b0;
    cfg_write(REG_WIDTH, 32'h0000_0000);
    cfg_write(REG_HEIGHT, 32'h0000_0005);
    cfg_write(REG_MODE, 32'(MODE_DILATE));
    queue_frames(1, 5, 1, 4, 1'b0, 1'b0, queued);
    cfg_write(REG_WIDTH, 32'h0000_07FF);
    cfg_write(REG_HEIGHT, 32'h0000_0000);
    cfg_write(REG_MODE, 32'(MODE_ERODE));
    for (int i = 0; i < MAX_W; i++) add_item(KIND_PIXEL, 1'($urandom_range(0, 7) != 0));
    frames_sent++;
    repeat (TAIL_DRAINS) push_drain();

    wait_idle();
    repeat (20) @(posedge clk);
    $display("checked %0d filtered pixels over %0d complete frames in dilate and erode",
             results_seen, frames_sent);
    $display("frame widths ran from 1 up to the 1024-pixel limit with random stalls on both sides");
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/bmf_pkg.sv
rtl/bmf_ram.sv
rtl/binary_morphology_filter.sv
bench/testbench.sv
